/* hw/rtl/lfpd_pkg.sv */
package lfpd_pkg;

  // Default sensor sample width
  localparam int SAMPLE_BITS_DEF = 11;

  // Fixed datapath widths
  localparam int GAIN_W   = 12;
  localparam int SMOOTH_W = 9;
  localparam int DRIVE_W  = 10;
  localparam int LIMIT_W  = 9;
  localparam int THRESH_W = 14;
  localparam int INTEG_W  = 24;
  localparam int CORR_W   = 16;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] REG_SMOOTH      = 3'd3;
  localparam logic [2:0] REG_CRUISE      = 3'd4;
  localparam logic [2:0] REG_LIMIT       = 3'd5;
  localparam logic [2:0] REG_THRESHOLD   = 3'd6;

  // Register reset values
  localparam logic [GAIN_W-1:0]          RST_PROP_GAIN  = 12'd256;
  localparam logic [GAIN_W-1:0]          RST_INTEG_GAIN = 12'd13;
  localparam logic [GAIN_W-1:0]          RST_DERIV_GAIN = 12'd640;
  localparam logic [SMOOTH_W-1:0]        RST_SMOOTH     = 9'd243;
  localparam logic signed [DRIVE_W-1:0]  RST_CRUISE     = 10'sd300;
  localparam logic [LIMIT_W-1:0]         RST_LIMIT      = 9'd400;
  localparam logic [THRESH_W-1:0]        RST_THRESHOLD  = 14'd1100;

  // Configuration seen by front and back
  typedef struct packed {
    logic [GAIN_W-1:0]         prop_gain;
    logic [GAIN_W-1:0]         integ_gain;
    logic [GAIN_W-1:0]         deriv_gain;
    logic [SMOOTH_W-1:0]       smooth_factor;
    logic signed [DRIVE_W-1:0] cruise_speed;
    logic [LIMIT_W-1:0]        speed_limit;
    logic [THRESH_W-1:0]       light_threshold;
  } cfg_t;

endpackage

/* hw/rtl/line_follow_pid_drive.sv */
// PID line follower for a differential drive.
// Input queue: drive reading_0..reading_4 and raise push; an item is taken
// at a clock edge where push is high and full is low. Result queue: while
// empty is low, left_drive, right_drive, pid_correction and line_seen show
// the oldest result; pop high at an edge takes it.
// The front updates the integral, last error and run flag in the cycle an
// item is taken and hands it to a two-entry queue. The back works one item
// at a time through one shared 13x24 gain multiplier and one shared
// smoothing multiplier: a 10-state sequence per item, taking the queue head
// included. The back takes a new item from the queue only in IDLE, so it
// finishes one item before it starts the next; the result reaches the
// ports from FIN, once the result register is free.
// When pop is held low the back holds its finished item, the queue fills
// and full rises; nothing is dropped.
// Reset (rst, synchronous) clears the integral, last error and smoothed
// speeds, sets the run flag, empties both queues and loads the register
// defaults. Registers sit on the APB port at byte address 4*index and
// should only be written while the block is idle.
module line_follow_pid_drive #(
  parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // Input items
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] reading_0,
  input  logic [SAMPLE_BITS-1:0] reading_1,
  input  logic [SAMPLE_BITS-1:0] reading_2,
  input  logic [SAMPLE_BITS-1:0] reading_3,
  input  logic [SAMPLE_BITS-1:0] reading_4,
  // Result items
  output logic                   empty,
  input  logic                   pop,
  output logic signed [lfpd_pkg::DRIVE_W-1:0] left_drive,
  output logic signed [lfpd_pkg::DRIVE_W-1:0] right_drive,
  output logic signed [lfpd_pkg::CORR_W-1:0]  pid_correction,
  output logic                   line_seen
);
  import lfpd_pkg::*;

  localparam int QW = 2 * SAMPLE_BITS + INTEG_W + 5;

  cfg_t       cfg;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain       <= RST_PROP_GAIN;
      cfg.integ_gain      <= RST_INTEG_GAIN;
      cfg.deriv_gain      <= RST_DERIV_GAIN;
      cfg.smooth_factor   <= RST_SMOOTH;
      cfg.cruise_speed    <= RST_CRUISE;
      cfg.speed_limit     <= RST_LIMIT;
      cfg.light_threshold <= RST_THRESHOLD;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PROP_GAIN:  cfg.prop_gain       <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN: cfg.integ_gain      <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN: cfg.deriv_gain      <= pwdata[GAIN_W-1:0];
        REG_SMOOTH:     cfg.smooth_factor   <= pwdata[SMOOTH_W-1:0];
        REG_CRUISE:     cfg.cruise_speed    <= $signed(pwdata[DRIVE_W-1:0]);
        REG_LIMIT:      cfg.speed_limit     <= pwdata[LIMIT_W-1:0];
        REG_THRESHOLD:  cfg.light_threshold <= pwdata[THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_PROP_GAIN:  prdata = 32'(cfg.prop_gain);
      REG_INTEG_GAIN: prdata = 32'(cfg.integ_gain);
      REG_DERIV_GAIN: prdata = 32'(cfg.deriv_gain);
      REG_SMOOTH:     prdata = 32'(cfg.smooth_factor);
      REG_CRUISE:     prdata = 32'(cfg.cruise_speed);
      REG_LIMIT:      prdata = 32'(cfg.speed_limit);
      REG_THRESHOLD:  prdata = 32'(cfg.light_threshold);
      default:        prdata = '0;
    endcase
  end

  logic          q_wr;
  logic          q_full;
  logic [QW-1:0] q_wdata;
  logic          q_rd;
  logic          q_valid;
  logic [QW-1:0] q_rdata;

  lfpd_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .reading_0 (reading_0),
    .reading_1 (reading_1),
    .reading_2 (reading_2),
    .reading_3 (reading_3),
    .reading_4 (reading_4),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_data    (q_wdata)
  );

  lfpd_fifo #(
    .DATA_W(QW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .valid   (q_valid)
  );

  lfpd_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_data         (q_rdata),
    .q_rd           (q_rd),
    .empty          (empty),
    .pop            (pop),
    .left_drive     (left_drive),
    .right_drive    (right_drive),
    .pid_correction (pid_correction),
    .line_seen      (line_seen)
  );

endmodule

/* hw/rtl/lfpd_fifo.sv */
module lfpd_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic [DATA_W-1:0] rd_data,
  output logic              valid
);
  import lfpd_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/lfpd_front.sv */
module lfpd_front #(
  parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lfpd_pkg::cfg_t         cfg,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] reading_0,
  input  logic [SAMPLE_BITS-1:0] reading_1,
  input  logic [SAMPLE_BITS-1:0] reading_2,
  input  logic [SAMPLE_BITS-1:0] reading_3,
  input  logic [SAMPLE_BITS-1:0] reading_4,
  input  logic                   q_full,
  output logic                   q_wr,
  output logic [2*SAMPLE_BITS+lfpd_pkg::INTEG_W+4:0] q_data
);
  import lfpd_pkg::*;

  localparam int ERR_W = SAMPLE_BITS + 1;
  localparam int DER_W = SAMPLE_BITS + 2;
  localparam int SUM_W = SAMPLE_BITS + 3;
  localparam int CMP_W = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
  localparam logic signed [INTEG_W:0] I_MAX = (INTEG_W + 1)'((1 << (INTEG_W - 1)) - 1);
  localparam logic signed [INTEG_W:0] I_MIN = -(INTEG_W + 1)'(1 << (INTEG_W - 1));

  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [ERR_W-1:0]   previous_error;
  logic                      running;

  logic signed [ERR_W-1:0]   err;
  logic signed [DER_W-1:0]   deriv;
  logic signed [INTEG_W:0]   integ_wide;
  logic signed [INTEG_W-1:0] integral_next;
  logic [CMP_W-1:0]          sum;
  logic                      seen;

  assign full = q_full;
  assign q_wr = push && !q_full;

  // Error, derivative and saturating integral
  always_comb begin
    err = $signed({1'b0, reading_1}) - $signed({1'b0, reading_3});
    deriv = DER_W'(err) - DER_W'(previous_error);
    integ_wide = (INTEG_W + 1)'(integral_sum) + (INTEG_W + 1)'(err);
    if (integ_wide > I_MAX) begin
      integral_next = INTEG_W'(I_MAX);
    end else if (integ_wide < I_MIN) begin
      integral_next = INTEG_W'(I_MIN);
    end else begin
      integral_next = INTEG_W'(integ_wide);
    end
  end

  // Light level against threshold
  always_comb begin
    sum = CMP_W'(reading_0) + CMP_W'(reading_1) + CMP_W'(reading_2)
        + CMP_W'(reading_3) + CMP_W'(reading_4);
    seen = (sum >= CMP_W'(cfg.light_threshold));
  end

  // Item handed to the back: new flag, previous flag, derivative, integral, error
  assign q_data = {seen, running, deriv, integral_next, err};

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
      running        <= 1'b1;
    end else if (q_wr) begin
      integral_sum   <= integral_next;
      previous_error <= err;
      running        <= seen;
    end
  end

endmodule

/* hw/rtl/lfpd_back.sv */
module lfpd_back #(
  parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lfpd_pkg::cfg_t         cfg,
  input  logic                   q_valid,
  input  logic [2*SAMPLE_BITS+lfpd_pkg::INTEG_W+4:0] q_data,
  output logic                   q_rd,
  output logic                   empty,
  input  logic                   pop,
  output logic signed [lfpd_pkg::DRIVE_W-1:0] left_drive,
  output logic signed [lfpd_pkg::DRIVE_W-1:0] right_drive,
  output logic signed [lfpd_pkg::CORR_W-1:0]  pid_correction,
  output logic                   line_seen
);
  import lfpd_pkg::*;

  localparam int ERR_W = SAMPLE_BITS + 1;
  localparam int DER_W = SAMPLE_BITS + 2;
  localparam int MA_W  = GAIN_W + 1;
  localparam int MB_W  = INTEG_W;
  localparam int MUL_W = MA_W + MB_W;
  localparam int ACC_W = MUL_W + 2;
  localparam int SPD_W = CORR_W + 1;
  localparam int DIF_W = DRIVE_W + 1;
  localparam int SF_W  = SMOOTH_W + 1;
  localparam int SP_W  = DIF_W + SF_W;
  localparam int SV_W  = SP_W + 1;

  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(255);
  localparam logic signed [ACC_W-1:0] C_MAX   = ACC_W'((1 << (CORR_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] C_MIN   = -ACC_W'(1 << (CORR_W - 1));

  // Sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_P     = 4'd1;
  localparam logic [3:0] ST_I     = 4'd2;
  localparam logic [3:0] ST_D     = 4'd3;
  localparam logic [3:0] ST_SUM   = 4'd4;
  localparam logic [3:0] ST_CORR  = 4'd5;
  localparam logic [3:0] ST_SPEED = 4'd6;
  localparam logic [3:0] ST_MR    = 4'd7;
  localparam logic [3:0] ST_ML    = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  logic [3:0] state;
  logic       out_valid;

  // Item fields
  logic signed [ERR_W-1:0]   err_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [DER_W-1:0]   deriv_r;
  logic                      run_prev;
  logic                      seen_r;

  // Working registers
  logic signed [ACC_W-1:0]   prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [CORR_W-1:0]  corr;
  logic signed [DRIVE_W-1:0] rs;
  logic signed [DRIVE_W-1:0] ls;
  logic signed [SP_W-1:0]    sprod;
  logic signed [DRIVE_W-1:0] smooth_right;
  logic signed [DRIVE_W-1:0] smooth_left;

  // Shared gain multiplier
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MUL_W-1:0] mul_y;

  always_comb begin
    case (state)
      ST_P: begin
        mul_a = $signed({1'b0, cfg.prop_gain});
        mul_b = MB_W'(err_r);
      end
      ST_I: begin
        mul_a = $signed({1'b0, cfg.integ_gain});
        mul_b = integ_r;
      end
      default: begin
        mul_a = $signed({1'b0, cfg.deriv_gain});
        mul_b = MB_W'(deriv_r);
      end
    endcase
    mul_y = mul_a * mul_b;
  end

  // Truncate toward zero and saturate the correction
  logic signed [ACC_W-1:0] acc_adj;
  logic signed [ACC_W-1:0] acc_div;
  logic signed [CORR_W-1:0] corr_next;

  always_comb begin
    acc_adj = acc[ACC_W-1] ? acc + ACC_RND : acc;
    acc_div = acc_adj >>> 8;
    if (acc_div > C_MAX) begin
      corr_next = CORR_W'(C_MAX);
    end else if (acc_div < C_MIN) begin
      corr_next = CORR_W'(C_MIN);
    end else begin
      corr_next = CORR_W'(acc_div);
    end
  end

  // Base speed plus and minus correction, clamped to the limit
  logic signed [SPD_W-1:0] r_sum;
  logic signed [SPD_W-1:0] l_sum;
  logic signed [SPD_W-1:0] lim_pos;
  logic signed [SPD_W-1:0] lim_neg;
  logic signed [DRIVE_W-1:0] rs_next;
  logic signed [DRIVE_W-1:0] ls_next;

  always_comb begin
    lim_pos = $signed(SPD_W'(cfg.speed_limit));
    lim_neg = -lim_pos;
    r_sum = SPD_W'(cfg.cruise_speed) + SPD_W'(corr);
    l_sum = SPD_W'(cfg.cruise_speed) - SPD_W'(corr);
    if (r_sum > lim_pos) begin
      rs_next = DRIVE_W'(lim_pos);
    end else if (r_sum < lim_neg) begin
      rs_next = DRIVE_W'(lim_neg);
    end else begin
      rs_next = DRIVE_W'(r_sum);
    end
    if (l_sum > lim_pos) begin
      ls_next = DRIVE_W'(lim_pos);
    end else if (l_sum < lim_neg) begin
      ls_next = DRIVE_W'(lim_neg);
    end else begin
      ls_next = DRIVE_W'(l_sum);
    end
  end

  // Shared smoothing multiplier: factor times (target - old)
  logic signed [DIF_W-1:0] s_diff;
  logic signed [SF_W-1:0]  s_fac;
  logic signed [SP_W-1:0]  s_mul;

  always_comb begin
    if (state == ST_MR) begin
      s_diff = DIF_W'(rs) - DIF_W'(smooth_right);
    end else begin
      s_diff = DIF_W'(ls) - DIF_W'(smooth_left);
    end
    s_fac = $signed({1'b0, cfg.smooth_factor});
    s_mul = s_fac * s_diff;
  end

  // old + product/256, truncated toward zero, saturated to drive width
  function automatic logic signed [DRIVE_W-1:0] smooth_finish(
    input logic signed [DRIVE_W-1:0] old,
    input logic signed [SP_W-1:0]    p
  );
    logic signed [SV_W-1:0] v;
    logic signed [SV_W-1:0] adj;
    logic signed [SV_W-1:0] q;
    logic signed [SV_W-1:0] hi;
    logic signed [SV_W-1:0] lo;
    v   = (SV_W'(old) <<< 8) + SV_W'(p);
    adj = v[SV_W-1] ? v + SV_W'(255) : v;
    q   = adj >>> 8;
    hi  = SV_W'((1 << (DRIVE_W - 1)) - 1);
    lo  = -SV_W'(1 << (DRIVE_W - 1));
    if (q > hi) begin
      smooth_finish = DRIVE_W'(hi);
    end else if (q < lo) begin
      smooth_finish = DRIVE_W'(lo);
    end else begin
      smooth_finish = DRIVE_W'(q);
    end
  endfunction

  logic signed [DRIVE_W-1:0] left_next;
  logic out_free;

  assign left_next = smooth_finish(smooth_left, sprod);
  assign out_free  = !out_valid || pop;
  assign q_rd      = (state == ST_IDLE) && q_valid;
  assign empty     = !out_valid;

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      smooth_right <= '0;
      smooth_left  <= '0;
    end else begin
      // FIN reloads the result register itself when it is free
      if (pop && out_valid && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_P;
          end
        end
        ST_P:     state <= ST_I;
        ST_I:     state <= ST_D;
        ST_D:     state <= ST_SUM;
        ST_SUM:   state <= ST_CORR;
        ST_CORR:  state <= ST_SPEED;
        ST_SPEED: state <= ST_MR;
        ST_MR:    state <= ST_ML;
        ST_ML: begin
          smooth_right <= smooth_finish(smooth_right, sprod);
          state        <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            smooth_left <= left_next;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        {seen_r, run_prev, deriv_r, integ_r, err_r} <= q_data;
      end
      ST_P: begin
        prod <= ACC_W'(mul_y);
      end
      ST_I: begin
        acc  <= prod;
        prod <= ACC_W'(mul_y);
      end
      ST_D: begin
        acc  <= acc + prod;
        prod <= ACC_W'(mul_y);
      end
      ST_SUM: begin
        acc <= acc + prod;
      end
      ST_CORR: begin
        corr <= corr_next;
      end
      ST_SPEED: begin
        rs <= rs_next;
        ls <= ls_next;
      end
      ST_MR, ST_ML: begin
        sprod <= s_mul;
      end
      ST_FIN: begin
        if (out_free) begin
          left_drive     <= run_prev ? left_next : '0;
          right_drive    <= run_prev ? smooth_right : '0;
          pid_correction <= corr;
          line_seen      <= seen_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
